/* src/kto_pkg.sv */
// Shared types, status codes and constants of the keyed time offset table.
package kto_pkg;

	localparam int TABLE_ENTRIES_DEFAULT = 16;
	localparam int CMD_DEPTH = 2;

	localparam logic [9:0] MILLIS_BASE = 10'd1000;
	localparam logic [9:0] MILLIS_MAX  = 10'd999;

	localparam logic OP_SET = 1'b0;
	localparam logic OP_GET = 1'b1;

	localparam logic [2:0] STATUS_OK        = 3'd0;
	localparam logic [2:0] STATUS_NOT_SET   = 3'd1;
	localparam logic [2:0] STATUS_OVERFLOW  = 3'd2;
	localparam logic [2:0] STATUS_BAD_PARAM = 3'd3;
	localparam logic [2:0] STATUS_FULL      = 3'd4;

	typedef struct packed {
		logic        opcode;
		logic [63:0] uuid_high;
		logic [63:0] uuid_low;
		logic [31:0] sys_seconds;
		logic [9:0]  sys_millis;
		logic [31:0] time_seconds;
		logic [31:0] time_millis;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] out_seconds;
		logic [9:0]  out_millis;
	} out_item_t;

	// classified command handed from front to back
	typedef struct packed {
		logic        opcode;
		logic        bad;
		logic [63:0] uuid_high;
		logic [63:0] uuid_low;
		logic [31:0] sys_seconds;
		logic [9:0]  sys_millis;
		logic [31:0] off_seconds;
		logic [9:0]  off_millis;
		logic        off_positive;
	} cmd_t;

	typedef struct packed {
		logic [63:0] key_high;
		logic [63:0] key_low;
		logic [31:0] off_seconds;
		logic [9:0]  off_millis;
		logic        off_positive;
	} entry_t;

endpackage

/* src/keyed_time_offset_table_unit.sv */
// Path: front stage register, command queue, then the back end, which scans the entries below
// count, executes, adds the steps G1, G2 and G3 for a get that hits and loads the result register;
// a bad-parameter set skips the scan. The back end holds one item at a time until its result
// is loaded; its single-ported entry scan limits how fast items go through.
// The front stage and a two-entry command queue accept items while the back works.
// Reset (arst_n low, asynchronous) empties the table and all queues at once.
module keyed_time_offset_table_unit #(
	parameter int TABLE_ENTRIES = kto_pkg::TABLE_ENTRIES_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  kto_pkg::in_item_t  item,
	output logic               full,
	output logic               empty,
	input  logic               pop,
	output kto_pkg::out_item_t result
);

	logic          f_push, q_full, q_empty, q_pop;
	kto_pkg::cmd_t f_cmd, q_cmd;

	kto_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.cmd_push (f_push),
		.cmd      (f_cmd),
		.cmd_full (q_full)
	);

	kto_cmd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.wdata  (f_cmd),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_cmd),
		.empty  (q_empty)
	);

	kto_back #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!q_empty),
		.cmd       (q_cmd),
		.cmd_pop   (q_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

/* src/kto_front.sv */
// Front end: accepts items, clamps millis, flags bad sets and computes the set offset.
module kto_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  kto_pkg::in_item_t item,
	output logic              full,
	output logic              cmd_push,
	output kto_pkg::cmd_t     cmd,
	input  logic              cmd_full
);

	logic              valid_s1;
	kto_pkg::in_item_t item_s1;
	logic              less_s1;
	logic              bad_s1;

	logic              accept;
	logic [9:0]        sm_clamp;
	kto_pkg::in_item_t item_clamp;
	logic [31:0]       as, bs, os;
	logic [9:0]        am, bm, om;
	logic              borrow;

	assign full     = valid_s1 && cmd_full;
	assign accept   = push && !full;
	assign cmd_push = valid_s1 && !cmd_full;
	assign sm_clamp = (item.sys_millis > kto_pkg::MILLIS_MAX) ? kto_pkg::MILLIS_MAX
		: item.sys_millis;

	always_comb begin
		item_clamp            = item;
		item_clamp.sys_millis = sm_clamp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && cmd_full);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_clamp;
			bad_s1  <= item.time_millis >= 32'(kto_pkg::MILLIS_BASE);
			less_s1 <= (item.sys_seconds < item.time_seconds)
				|| (item.sys_seconds == item.time_seconds
				&& 32'(sm_clamp) < item.time_millis);
		end
	end

	// larger time minus smaller time, borrow across the millis digit
	always_comb begin
		if (less_s1) begin
			as = item_s1.time_seconds;
			am = item_s1.time_millis[9:0];
			bs = item_s1.sys_seconds;
			bm = item_s1.sys_millis;
		end else begin
			as = item_s1.sys_seconds;
			am = item_s1.sys_millis;
			bs = item_s1.time_seconds;
			bm = item_s1.time_millis[9:0];
		end
		borrow = am < bm;
		os     = as - bs - 32'(borrow);
		om     = borrow ? 10'(11'(am) + 11'(kto_pkg::MILLIS_BASE) - 11'(bm)) : (am - bm);
	end

	always_comb begin
		cmd.opcode       = item_s1.opcode;
		cmd.bad          = bad_s1;
		cmd.uuid_high    = item_s1.uuid_high;
		cmd.uuid_low     = item_s1.uuid_low;
		cmd.sys_seconds  = item_s1.sys_seconds;
		cmd.sys_millis   = item_s1.sys_millis;
		cmd.off_seconds  = os;
		cmd.off_millis   = om;
		cmd.off_positive = less_s1;
	end

endmodule

/* src/kto_cmd_queue.sv */
// Short command queue between front and back.
module kto_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  kto_pkg::cmd_t wdata,
	output logic          full,
	input  logic          pop,
	output kto_pkg::cmd_t rdata,
	output logic          empty
);

	localparam int PTR_W = (kto_pkg::CMD_DEPTH > 1) ? $clog2(kto_pkg::CMD_DEPTH) : 1;
	localparam int CNT_W = $clog2(kto_pkg::CMD_DEPTH + 1);

	kto_pkg::cmd_t    slot_q [kto_pkg::CMD_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full    = cnt_q == CNT_W'(kto_pkg::CMD_DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(kto_pkg::CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(kto_pkg::CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= wdata;
	end

endmodule

/* src/kto_back.sv */
// Back end: table scan, set/get execution and the result register.
module kto_back #(
	parameter int TABLE_ENTRIES = kto_pkg::TABLE_ENTRIES_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  kto_pkg::cmd_t      cmd,
	output logic               cmd_pop,
	output kto_pkg::out_item_t result,
	output logic               empty,
	input  logic               pop
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_EXEC = 3'd2;
	localparam logic [2:0] S_G1   = 3'd3;
	localparam logic [2:0] S_G2   = 3'd4;
	localparam logic [2:0] S_G3   = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	kto_pkg::entry_t    mem [TABLE_ENTRIES];
	kto_pkg::entry_t    rd_q;
	kto_pkg::entry_t    hit_q;
	kto_pkg::entry_t    wr_entry;
	kto_pkg::cmd_t      cmd_q;
	kto_pkg::out_item_t res_q;

	logic [2:0]         state_q;
	logic [CNT_W-1:0]   count_q, scan_q;
	logic               cmp_v_q, hit_v_q, res_valid_q;
	logic [IDX_W-1:0]   cmp_idx_q, hit_idx_q;
	logic [IDX_W-1:0]   rd_idx, wr_idx;
	logic               wr_en, match, room, is_set;
	logic [31:0]        sum_q, rs_q;
	logic [10:0]        msum_q;
	logic               mborrow_q;
	logic [9:0]         rm_q;
	logic [2:0]         st_q;
	logic               slot_free;
	logic               load_res;

	assign rd_idx    = scan_q[IDX_W-1:0];
	assign match     = cmp_v_q && rd_q.key_high == cmd_q.uuid_high
		&& rd_q.key_low == cmd_q.uuid_low;
	assign room      = count_q < CNT_W'(TABLE_ENTRIES);
	assign is_set    = cmd_q.opcode == kto_pkg::OP_SET;
	assign wr_en     = state_q == S_EXEC && is_set && (hit_v_q || room);
	assign wr_idx    = hit_v_q ? hit_idx_q : count_q[IDX_W-1:0];
	assign cmd_pop   = state_q == S_IDLE && cmd_valid;
	assign slot_free = !res_valid_q || pop;
	assign load_res  = state_q == S_DONE && slot_free;
	assign empty     = !res_valid_q;
	assign result    = res_q;

	always_comb begin
		wr_entry.key_high     = cmd_q.uuid_high;
		wr_entry.key_low      = cmd_q.uuid_low;
		wr_entry.off_seconds  = cmd_q.off_seconds;
		wr_entry.off_millis   = cmd_q.off_millis;
		wr_entry.off_positive = cmd_q.off_positive;
	end

	// only entries below count_q are ever compared, so the store needs no clearing
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_idx] <= wr_entry;
		rd_q <= mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			scan_q      <= '0;
			cmp_v_q     <= 1'b0;
			hit_v_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (load_res)
				res_valid_q <= 1'b1;
			else if (pop && res_valid_q)
				res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q   <= cmd;
						scan_q  <= '0;
						cmp_v_q <= 1'b0;
						hit_v_q <= 1'b0;
						rs_q    <= '0;
						rm_q    <= '0;
						if (cmd.opcode == kto_pkg::OP_SET && cmd.bad) begin
							st_q    <= kto_pkg::STATUS_BAD_PARAM;
							state_q <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// read at scan_q while comparing the entry read last cycle
					if (match) begin
						hit_v_q   <= 1'b1;
						hit_idx_q <= cmp_idx_q;
						hit_q     <= rd_q;
						cmp_v_q   <= 1'b0;
						state_q   <= S_EXEC;
					end else if (scan_q < count_q) begin
						cmp_v_q   <= 1'b1;
						cmp_idx_q <= rd_idx;
						scan_q    <= scan_q + 1'b1;
					end else begin
						cmp_v_q <= 1'b0;
						if (!cmp_v_q)
							state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (is_set) begin
						if (hit_v_q) begin
							st_q <= kto_pkg::STATUS_OK;
						end else if (room) begin
							st_q    <= kto_pkg::STATUS_OK;
							count_q <= count_q + 1'b1;
						end else begin
							st_q <= kto_pkg::STATUS_FULL;
						end
						state_q <= S_DONE;
					end else if (!hit_v_q) begin
						st_q    <= kto_pkg::STATUS_NOT_SET;
						state_q <= S_DONE;
					end else begin
						state_q <= S_G1;
					end
				end
				S_G1: begin
					if (hit_q.off_positive) begin
						sum_q  <= cmd_q.sys_seconds + hit_q.off_seconds;
						msum_q <= 11'(cmd_q.sys_millis) + 11'(hit_q.off_millis);
					end else begin
						sum_q  <= cmd_q.sys_seconds - hit_q.off_seconds;
						msum_q <= 11'(cmd_q.sys_millis) - 11'(hit_q.off_millis);
					end
					mborrow_q <= cmd_q.sys_millis < hit_q.off_millis;
					state_q   <= S_G2;
				end
				S_G2: begin
					// millis carry or borrow in base 1000
					if (hit_q.off_positive) begin
						if (msum_q >= 11'(kto_pkg::MILLIS_BASE)) begin
							rs_q <= sum_q + 32'd1;
							rm_q <= 10'(msum_q - 11'(kto_pkg::MILLIS_BASE));
						end else begin
							rs_q <= sum_q;
							rm_q <= msum_q[9:0];
						end
					end else if (mborrow_q) begin
						rs_q <= sum_q - 32'd1;
						rm_q <= 10'(msum_q + 11'(kto_pkg::MILLIS_BASE));
					end else begin
						rs_q <= sum_q;
						rm_q <= msum_q[9:0];
					end
					state_q <= S_G3;
				end
				S_G3: begin
					if (hit_q.off_positive ?
						(rs_q < cmd_q.sys_seconds
						|| (rs_q == cmd_q.sys_seconds && rm_q < cmd_q.sys_millis)) :
						(cmd_q.sys_seconds < rs_q
						|| (cmd_q.sys_seconds == rs_q && cmd_q.sys_millis < rm_q)))
						st_q <= kto_pkg::STATUS_OVERFLOW;
					else
						st_q <= kto_pkg::STATUS_OK;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (load_res) begin
						res_q.status      <= st_q;
						res_q.out_seconds <= rs_q;
						res_q.out_millis  <= rm_q;
						state_q           <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_ENTRIES))
		else $error("entry count beyond table size");

	a_write_exec: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> state_q == S_EXEC && cmd_q.opcode == kto_pkg::OP_SET)
		else $error("table write outside set execution");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !$past(res_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result loaded outside done state");

	a_count_grows_on_append: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EXEC && wr_en && !hit_v_q |=> count_q == $past(count_q) + 1'b1)
		else $error("append did not grow the table");

	a_notset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.status == kto_pkg::STATUS_NOT_SET
		|-> res_q.out_seconds == '0 && res_q.out_millis == '0)
		else $error("not-set result carries a time");

endmodule

/* test/keyed_time_offset_table_unit_tb.sv */
// Self-checking bench for the keyed time offset table: directed table, then random traffic.
module keyed_time_offset_table_unit_tb;

	localparam int ENTRIES      = kto_pkg::TABLE_ENTRIES_DEFAULT;
	localparam int RANDOM_ITEMS = 950;
	localparam int CALM_TAIL    = 150;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 40;
	localparam int REPORT_MAX   = 10;

	localparam logic [63:0] KEY_A_HI = 64'hA5A5_0123_4567_89AB;
	localparam logic [63:0] KEY_A_LO = 64'h5A5A_FEDC_BA98_7654;
	localparam logic [63:0] KEY_B_HI = 64'h0000_0000_0000_0001;
	localparam logic [63:0] KEY_B_LO = 64'h8000_0000_0000_0000;
	localparam logic [63:0] KEY_C_HI = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] KEY_C_LO = 64'hFFFF_FFFF_FFFF_FFFE;
	localparam logic [63:0] FILL_HI  = 64'hF111_0000_0000_0000;

	typedef struct {
		kto_pkg::in_item_t  stim;
		bit                 fixed;
		kto_pkg::out_item_t want;
	} plan_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	kto_pkg::in_item_t  item = '0;
	logic               full;
	logic               empty;
	logic               pop = 1'b0;
	kto_pkg::out_item_t result;

	// offset table as the bench sees it
	logic [63:0] tbl_hi [ENTRIES];
	logic [63:0] tbl_lo [ENTRIES];
	logic [31:0] tbl_sec [ENTRIES];
	logic [9:0]  tbl_ms [ENTRIES];
	logic        tbl_ahead [ENTRIES];
	int          tbl_used = 0;

	kto_pkg::out_item_t pending_resp[$];
	plan_row_t          plan[$];

	int  mismatches = 0;
	int  sets_sent = 0;
	int  gets_sent = 0;
	int  full_stalls = 0;
	int  status_seen [8];
	int  tx_idle_pct = 20;
	int  rx_idle_pct = 20;
	bit  no_idle = 1'b0;
	bit  hold_go = 1'b0;
	bit  rx_hold = 1'b0;

	keyed_time_offset_table_unit #(
		.TABLE_ENTRIES(ENTRIES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.item(item),
		.full(full),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("timeout: %0d results still outstanding", pending_resp.size());
		$display("keyed_time_offset_table_unit_tb: FAIL");
		$finish;
	end

	function automatic bit earlier(input logic [31:0] as, input logic [9:0] am,
			input logic [31:0] bs, input logic [9:0] bm);
		return (as < bs) || (as == bs && am < bm);
	endfunction

	function automatic int lookup(input logic [63:0] hi, input logic [63:0] lo);
		for (int n = 0; n < tbl_used; n++) begin
			if (tbl_hi[n] == hi && tbl_lo[n] == lo)
				return n;
		end
		return -1;
	endfunction

	// Expected response for one transfer; updates the bench's table copy.
	function automatic kto_pkg::out_item_t predict_time(input kto_pkg::in_item_t req);
		kto_pkg::out_item_t r;
		logic [9:0]         sm, wm, a_m, b_m, om;
		logic [31:0]        a_s, b_s, os;
		logic [10:0]        msum;
		logic               ahead;
		int                 idx;
		r = '0;
		r.status = kto_pkg::STATUS_OK;
		sm = (req.sys_millis > kto_pkg::MILLIS_MAX) ? kto_pkg::MILLIS_MAX : req.sys_millis;
		idx = lookup(req.uuid_high, req.uuid_low);
		if (req.opcode == kto_pkg::OP_SET) begin
			if (req.time_millis >= 32'(kto_pkg::MILLIS_BASE)) begin
				r.status = kto_pkg::STATUS_BAD_PARAM;
			end else begin
				wm = req.time_millis[9:0];
				ahead = earlier(req.sys_seconds, sm, req.time_seconds, wm);
				if (ahead) begin
					a_s = req.time_seconds; a_m = wm; b_s = req.sys_seconds; b_m = sm;
				end else begin
					a_s = req.sys_seconds; a_m = sm; b_s = req.time_seconds; b_m = wm;
				end
				os = a_s - b_s;
				if (a_m < b_m) begin
					os = os - 32'd1;
					om = a_m + kto_pkg::MILLIS_BASE - b_m;
				end else begin
					om = a_m - b_m;
				end
				if (idx < 0) begin
					if (tbl_used >= ENTRIES) begin
						r.status = kto_pkg::STATUS_FULL;
					end else begin
						idx = tbl_used;
						tbl_hi[idx] = req.uuid_high;
						tbl_lo[idx] = req.uuid_low;
						tbl_used++;
					end
				end
				if (r.status == kto_pkg::STATUS_OK) begin
					tbl_sec[idx] = os;
					tbl_ms[idx] = om;
					tbl_ahead[idx] = ahead;
				end
			end
		end else if (idx < 0) begin
			r.status = kto_pkg::STATUS_NOT_SET;
		end else if (tbl_ahead[idx]) begin
			r.out_seconds = req.sys_seconds + tbl_sec[idx];
			msum = {1'b0, sm} + {1'b0, tbl_ms[idx]};
			if (msum >= 11'(kto_pkg::MILLIS_BASE)) begin
				r.out_seconds = r.out_seconds + 32'd1;
				msum = msum - 11'(kto_pkg::MILLIS_BASE);
			end
			r.out_millis = msum[9:0];
			if (earlier(r.out_seconds, r.out_millis, req.sys_seconds, sm))
				r.status = kto_pkg::STATUS_OVERFLOW;
		end else begin
			r.out_seconds = req.sys_seconds - tbl_sec[idx];
			if (sm < tbl_ms[idx]) begin
				r.out_seconds = r.out_seconds - 32'd1;
				r.out_millis = sm + kto_pkg::MILLIS_BASE - tbl_ms[idx];
			end else begin
				r.out_millis = sm - tbl_ms[idx];
			end
			if (earlier(req.sys_seconds, sm, r.out_seconds, r.out_millis))
				r.status = kto_pkg::STATUS_OVERFLOW;
		end
		return r;
	endfunction

	function automatic kto_pkg::in_item_t mk(input logic op, input logic [63:0] hi,
			input logic [63:0] lo, input logic [31:0] ss, input logic [9:0] sm,
			input logic [31:0] ws, input logic [31:0] wm);
		kto_pkg::in_item_t r;
		r.opcode = op;
		r.uuid_high = hi;
		r.uuid_low = lo;
		r.sys_seconds = ss;
		r.sys_millis = sm;
		r.time_seconds = ws;
		r.time_millis = wm;
		return r;
	endfunction

	function automatic kto_pkg::out_item_t resp(input logic [2:0] st, input logic [31:0] s,
			input logic [9:0] m);
		kto_pkg::out_item_t r;
		r.status = st;
		r.out_seconds = s;
		r.out_millis = m;
		return r;
	endfunction

	function automatic void add_row(input kto_pkg::in_item_t s, input bit f,
			input kto_pkg::out_item_t w);
		plan_row_t row;
		row.stim = s;
		row.fixed = f;
		row.want = w;
		plan.push_back(row);
	endfunction

	function automatic logic [31:0] rnd_secs();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(0, 15);
			3: return 32'hFFFF_FFFF - $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [9:0] rnd_millis();
		case ($urandom_range(0, 4))
			0: return 10'd0;
			1: return kto_pkg::MILLIS_MAX;
			default: return 10'($urandom_range(0, 999));
		endcase
	endfunction

	// Mostly known keys with well-formed times; the rest unknown keys and bad fields.
	function automatic kto_pkg::in_item_t random_request();
		kto_pkg::in_item_t r;
		int                k;
		int                pick;
		k = $urandom_range(0, ENTRIES - 1);
		r.opcode = ($urandom_range(0, 99) < 45) ? kto_pkg::OP_SET : kto_pkg::OP_GET;
		r.uuid_high = tbl_hi[k];
		r.uuid_low = tbl_lo[k];
		r.sys_seconds = rnd_secs();
		r.sys_millis = rnd_millis();
		r.time_seconds = rnd_secs();
		r.time_millis = 32'(rnd_millis());
		if ($urandom_range(0, 2) == 0)
			r.time_seconds = r.sys_seconds + $urandom_range(0, 3) - $urandom_range(0, 3);
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			r.uuid_high = {$urandom, $urandom};
			r.uuid_low = {$urandom, $urandom};
		end else if (pick < 18) begin
			// one half matches a stored key, the other does not
			if ($urandom_range(0, 1))
				r.uuid_high = {$urandom, $urandom};
			else
				r.uuid_low = {$urandom, $urandom};
		end else if (pick < 24) begin
			case ($urandom_range(0, 2))
				0: r.time_millis = 32'd1000;
				1: r.time_millis = 32'hFFFF_FFFF;
				default: r.time_millis = $urandom;
			endcase
		end else if (pick < 30) begin
			r.sys_millis = 10'($urandom_range(1000, 1023));
		end
		return r;
	endfunction

	task automatic offer_request(input kto_pkg::in_item_t req, input bit fixed,
			input kto_pkg::out_item_t want);
		kto_pkg::out_item_t calc;
		item <= req;
		push <= 1'b1;
		@(posedge clk);
		while (full)
			@(posedge clk);
		calc = predict_time(req);
		pending_resp.push_back(fixed ? want : calc);
		if (req.opcode == kto_pkg::OP_SET)
			sets_sent++;
		else
			gets_sent++;
		@(negedge clk);
	endtask

	task automatic pause_sender();
		int gap;
		if (!no_idle && $urandom_range(0, 99) < tx_idle_pct) begin
			gap = $urandom_range(1, 7);
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// receiver: random pop bursts, long hold-off on request
	initial begin
		int rx_gap;
		rx_gap = 0;
		forever begin
			@(negedge clk);
			if (rx_hold) begin
				pop <= 1'b0;
			end else if (rx_gap > 0) begin
				pop <= 1'b0;
				rx_gap--;
			end else if (!no_idle && $urandom_range(0, 99) < rx_idle_pct) begin
				pop <= 1'b0;
				rx_gap = $urandom_range(1, 7) - 1;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		wait (hold_go);
		@(posedge clk);
		rx_hold = 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		rx_hold = 1'b0;
	end

	always @(posedge clk) begin
		kto_pkg::out_item_t exp_r;
		if (arst_n && push && full)
			full_stalls++;
		if (arst_n && pop && !empty) begin
			status_seen[result.status]++;
			if (pending_resp.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected transfer: status %0d sec %h ms %0d",
						result.status, result.out_seconds, result.out_millis);
			end else begin
				exp_r = pending_resp.pop_front();
				if (result.status !== exp_r.status || result.out_seconds !== exp_r.out_seconds
						|| result.out_millis !== exp_r.out_millis) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display({"mismatch: expected status %0d sec %h ms %0d, ",
							"got status %0d sec %h ms %0d"},
							exp_r.status, exp_r.out_seconds, exp_r.out_millis,
							result.status, result.out_seconds, result.out_millis);
				end
			end
		end
	end

	initial begin
		for (int n = 0; n < 8; n++)
			status_seen[n] = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty table, bad millis, zero offset, extreme offsets both ways,
		// clamped system millis, partial key match, then fill and overflow the table
		add_row(mk(kto_pkg::OP_GET, 64'd0, 64'd0, 32'd0, 10'd0, 32'd0, 32'd0), 1'b1,
			resp(kto_pkg::STATUS_NOT_SET, 32'd0, 10'd0));
		add_row(mk(kto_pkg::OP_SET, '1, '1, '1, kto_pkg::MILLIS_MAX, '1, 32'd1000), 1'b1,
			resp(kto_pkg::STATUS_BAD_PARAM, 32'd0, 10'd0));
		add_row(mk(kto_pkg::OP_SET, 64'd0, 64'd0, 32'd0, 10'd0, 32'd0, 32'hFFFF_FFFF), 1'b1,
			resp(kto_pkg::STATUS_BAD_PARAM, 32'd0, 10'd0));
		add_row(mk(kto_pkg::OP_SET, 64'd0, 64'd0, 32'd0, 10'd0, 32'd0, 32'd0), 1'b1,
			resp(kto_pkg::STATUS_OK, 32'd0, 10'd0));
		add_row(mk(kto_pkg::OP_GET, 64'd0, 64'd0, '1, kto_pkg::MILLIS_MAX, 32'd0, 32'd0), 1'b1,
			resp(kto_pkg::STATUS_OK, 32'hFFFF_FFFF, kto_pkg::MILLIS_MAX));
		add_row(mk(kto_pkg::OP_SET, KEY_A_HI, KEY_A_LO, 32'd0, 10'd0, '1, 32'd999), 1'b1,
			resp(kto_pkg::STATUS_OK, 32'd0, 10'd0));
		add_row(mk(kto_pkg::OP_GET, KEY_A_HI, KEY_A_LO, 32'd0, 10'd0, 32'd0, 32'd0),
			1'b0, '0);
		add_row(mk(kto_pkg::OP_GET, KEY_A_HI, KEY_A_LO, 32'd0, 10'd1, 32'd0, 32'd0),
			1'b0, '0);
		add_row(mk(kto_pkg::OP_SET, KEY_B_HI, KEY_B_LO, '1, kto_pkg::MILLIS_MAX, 32'd0, 32'd0),
			1'b1, resp(kto_pkg::STATUS_OK, 32'd0, 10'd0));
		add_row(mk(kto_pkg::OP_GET, KEY_B_HI, KEY_B_LO, 32'd0, 10'd0, 32'd0, 32'd0),
			1'b0, '0);
		add_row(mk(kto_pkg::OP_GET, KEY_B_HI, KEY_B_LO, '1, kto_pkg::MILLIS_MAX, 32'd0, 32'd0),
			1'b0, '0);
		add_row(mk(kto_pkg::OP_SET, KEY_C_HI, KEY_C_LO, 32'd5, 10'd1023, 32'd5, 32'd999),
			1'b0, '0);
		add_row(mk(kto_pkg::OP_SET, KEY_A_HI, ~KEY_A_LO, 32'd100, 10'd500, 32'd99, 32'd700),
			1'b0, '0);
		for (int n = 0; n < ENTRIES - 5; n++)
			add_row(mk(kto_pkg::OP_SET, FILL_HI | 64'(n), {$urandom, $urandom}, $urandom,
				10'($urandom_range(0, 999)), $urandom, $urandom_range(0, 999)), 1'b0, '0);
		add_row(mk(kto_pkg::OP_SET, ~KEY_A_HI, KEY_A_LO, 32'd1, 10'd1, 32'd2, 32'd2), 1'b1,
			resp(kto_pkg::STATUS_FULL, 32'd0, 10'd0));

		foreach (plan[n]) begin
			offer_request(plan[n].stim, plan[n].fixed, plan[n].want);
			pause_sender();
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 50 == 0) begin
				tx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
				rx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
			end
			if (n == 100) begin
				// keep offering while the receiver holds off so the input backs up
				tx_idle_pct = 0;
				hold_go = 1'b1;
			end
			if (n == RANDOM_ITEMS - CALM_TAIL)
				no_idle = 1'b1;
			offer_request(random_request(), 1'b0, '0);
			pause_sender();
		end
		push <= 1'b0;

		while (pending_resp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d sets and %0d gets on a %0d-entry table; input held off %0d cycles",
			sets_sent, gets_sent, ENTRIES, full_stalls);
		$display({"statuses seen: ok %0d, not set %0d, overflow %0d, bad param %0d, ",
			"full %0d; %0d mismatches"},
			status_seen[kto_pkg::STATUS_OK], status_seen[kto_pkg::STATUS_NOT_SET],
			status_seen[kto_pkg::STATUS_OVERFLOW], status_seen[kto_pkg::STATUS_BAD_PARAM],
			status_seen[kto_pkg::STATUS_FULL], mismatches);
		if (mismatches == 0)
			$display("keyed_time_offset_table_unit_tb: PASS");
		else
			$display("keyed_time_offset_table_unit_tb: FAIL");
		$finish;
	end

endmodule
